FILE: rtl/bsup_pkg.sv
// Package for the battery supervisor: field widths, fixed constants, register indexes,
// reset values, phase codes and the mode type.
// No dependencies.
package bsup_pkg;

   // Field widths
   localparam int VOLT_W      = 16;
   localparam int CURR_W      = 16;
   localparam int CELLS_W     = 5;
   localparam int PHASE_W     = 2;
   localparam int LEVEL_W     = 13;
   localparam int WM_W        = CELLS_W + LEVEL_W;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;

   // Window depth default and fixed constants
   localparam int WINDOW_DEFAULT = 5;
   localparam int REPORT_EVERY   = 5;
   localparam int REPORT_W       = 3;
   localparam int LOW_RUN_LIMIT  = 10;
   localparam int LOW_RUN_W      = 4;
   localparam int CELL_NOMINAL_MV = 3700;

   // Exact floor(av / 3700) for any 16-bit av: multiply, then shift
   localparam int CELL_DIV_SHIFT = 28;
   localparam int CELL_RECIP_W   = 17;
   localparam int CELL_RECIP     =
      ((1 << CELL_DIV_SHIFT) + CELL_NOMINAL_MV - 1) / CELL_NOMINAL_MV;

   // Register indexes on the CSR write port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HEALTH_LIMIT = 3'd0,
      CSR_ONE_CELL     = 3'd1,
      CSR_TWO_CELL     = 3'd2,
      CSR_THREE_CELL   = 3'd3,
      CSR_FOUR_CELL    = 3'd4,
      CSR_LOW_LEVEL    = 3'd5,
      CSR_CURR_LIMIT   = 3'd6,
      CSR_FORCED_CELLS = 3'd7
   } csr_index_type;

   // Register reset values
   localparam logic [VOLT_W-1:0]  HEALTH_LIMIT_RST = 16'd3000;
   localparam logic [VOLT_W-1:0]  ONE_CELL_RST     = 16'd4350;
   localparam logic [VOLT_W-1:0]  TWO_CELL_RST     = 16'd8700;
   localparam logic [VOLT_W-1:0]  THREE_CELL_RST   = 16'd13050;
   localparam logic [VOLT_W-1:0]  FOUR_CELL_RST    = 16'd17400;
   localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST    = 13'd3300;
   localparam logic [CURR_W-1:0]  CURR_LIMIT_RST   = 16'd20000;
   localparam logic [CELLS_W-1:0] FORCED_CELLS_RST = 5'd0;

   // Phase codes on the result word
   localparam logic [PHASE_W-1:0] PHASE_WARM   = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_RUN    = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_ABSENT = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_SLEEP  = 2'd3;

   // Supervisor mode
   typedef enum logic [3:0] {
      MODE_WARM   = 4'b0001,
      MODE_RUN    = 4'b0010,
      MODE_ABSENT = 4'b0100,
      MODE_SLEEP  = 4'b1000
   } mode_type;

endpackage

FILE: rtl/bsup_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bsup_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write, and register the read word; hold it while no read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/battery_supervisor.sv
// Battery supervisor: pipelined from an accepted req word to rsp_tvalid;
// throughput one word per cycle while rsp_tready does not hold the output, set by the
// window RAM (one read, one write per cycle) and the mode update in the last stage.
// Reset (synchronous) loads the limit registers with their defaults, empties the
// pipeline, clears the sums, mode and counters and the per-entry valid bits so
// the windows read as zero; there is no clearing pass. Uses bsup_pkg, bsup_ram.
module battery_supervisor
   import bsup_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: sample_voltage_mv[15:0], sample_current_ma[31:16],
   //            motor_stopped[32], zero fill [39:33]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: avg_voltage_mv[15:0], avg_current_ma[31:16], cell_count[36:32],
   //            phase[38:37], overcurrent[39]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: report_valid[0]
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_W     = $clog2(WINDOW);
   localparam int WARM_W    = $clog2(WINDOW + 1);
   localparam int SUM_W     = VOLT_W + $clog2(WINDOW);
   localparam int ENTRY_W   = VOLT_W + CURR_W;
   // Exact floor(n / WINDOW) for n below 2**SUM_W by reciprocal multiply
   localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
   localparam int RECIP_W   = SUM_W + 1;
   localparam int DIV_RECIP = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int CPROD_W   = VOLT_W + CELL_RECIP_W;

   localparam logic [RECIP_W-1:0]      RECIP      = RECIP_W'(DIV_RECIP);
   localparam logic [CELL_RECIP_W-1:0] CELL_RECIP_V = CELL_RECIP_W'(CELL_RECIP);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [VOLT_W-1:0]  health_limit_ff, one_cell_ff, two_cell_ff;
   logic [VOLT_W-1:0]  three_cell_ff, four_cell_ff;
   logic [LEVEL_W-1:0] low_level_ff;
   logic [CURR_W-1:0]  curr_limit_ff;
   logic [CELLS_W-1:0] forced_cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         health_limit_ff <= HEALTH_LIMIT_RST;
         one_cell_ff     <= ONE_CELL_RST;
         two_cell_ff     <= TWO_CELL_RST;
         three_cell_ff   <= THREE_CELL_RST;
         four_cell_ff    <= FOUR_CELL_RST;
         low_level_ff    <= LOW_LEVEL_RST;
         curr_limit_ff   <= CURR_LIMIT_RST;
         forced_cells_ff <= FORCED_CELLS_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_HEALTH_LIMIT: health_limit_ff <= csr_wdata;
            CSR_ONE_CELL:     one_cell_ff     <= csr_wdata;
            CSR_TWO_CELL:     two_cell_ff     <= csr_wdata;
            CSR_THREE_CELL:   three_cell_ff   <= csr_wdata;
            CSR_FOUR_CELL:    four_cell_ff    <= csr_wdata;
            CSR_LOW_LEVEL:    low_level_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_CURR_LIMIT:   curr_limit_ff   <= csr_wdata;
            CSR_FORCED_CELLS: forced_cells_ff <= csr_wdata[CELLS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow: each stage loads when the next one is free or moving
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic rsp_valid_ff;
   logic take1, take2, take3, take4, take5, take_out;
   logic req_fire, s1_fire, s5_fire;

   assign take_out   = !rsp_valid_ff || rsp_tready;
   assign take5      = !s5_valid_ff  || take_out;
   assign take4      = !s4_valid_ff  || take5;
   assign take3      = !s3_valid_ff  || take4;
   assign take2      = !s2_valid_ff  || take3;
   assign take1      = !s1_valid_ff  || take2;
   assign req_tready = take1;
   assign req_fire   = req_tvalid && take1;
   assign s1_fire    = s1_valid_ff && take2;
   assign s5_fire    = s5_valid_ff && take_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1)    s1_valid_ff  <= req_tvalid;
         if (take2)    s2_valid_ff  <= s1_valid_ff;
         if (take3)    s3_valid_ff  <= s2_valid_ff;
         if (take4)    s4_valid_ff  <= s3_valid_ff;
         if (take5)    s5_valid_ff  <= s4_valid_ff;
         if (take_out) rsp_valid_ff <= s5_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0/1: window RAM read at accept, sum update and write back.
   // Consecutive words use different entries, and a word reads its entry
   // no earlier than the cycle after the previous writer wrote it.
   // ------------------------------------------------------------------
   logic [POS_W-1:0]   pos_ff;
   logic [WINDOW-1:0]  entry_vld_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic               s1_old_vld_ff;
   logic [VOLT_W-1:0]  s1_volt_ff;
   logic [CURR_W-1:0]  s1_curr_ff;
   logic               s1_stopped_ff;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [SUM_W-1:0]   vsum_ff, csum_ff;
   logic [SUM_W-1:0]   vsum_in, csum_in;
   logic [VOLT_W-1:0]  old_volt;
   logic [CURR_W-1:0]  old_curr;

   bsup_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_pos_ff),
      .wr_data ({s1_curr_ff, s1_volt_ff}),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // Advance the shared write position and capture the word
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_fire) begin
         pos_ff <= (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         s1_pos_ff     <= pos_ff;
         s1_old_vld_ff <= entry_vld_ff[pos_ff];
         s1_volt_ff    <= req_tdata[VOLT_W-1:0];
         s1_curr_ff    <= req_tdata[VOLT_W +: CURR_W];
         s1_stopped_ff <= req_tdata[VOLT_W + CURR_W];
      end
   end

   // An entry never written reads as zero
   assign old_volt = s1_old_vld_ff ? ram_rd_data[VOLT_W-1:0] : '0;
   assign old_curr = s1_old_vld_ff ? ram_rd_data[VOLT_W +: CURR_W] : '0;

   // Drop the oldest sample from the running sums, add the new one
   always_comb begin
      vsum_in = vsum_ff - SUM_W'(old_volt) + SUM_W'(s1_volt_ff);
      csum_in = csum_ff - SUM_W'(signed'(old_curr)) + SUM_W'(signed'(s1_curr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vsum_ff      <= '0;
         csum_ff      <= '0;
         entry_vld_ff <= '0;
      end else if (s1_fire) begin
         vsum_ff                 <= vsum_in;
         csum_ff                 <= csum_in;
         entry_vld_ff[s1_pos_ff] <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: reciprocal multiply for the floored averages.
   // Negative current: floor(s/W) = ~floor(~s/W).
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]  s2_vsum_ff, s2_csum_ff;
   logic              s2_stopped_ff;
   logic [SUM_W-1:0]  cmag;
   logic [PROD_W-1:0] s3_vprod_ff, s3_cprod_ff;
   logic              s3_neg_ff, s3_stopped_ff;

   always_ff @(posedge clock) begin
      if (take2) begin
         s2_vsum_ff    <= vsum_in;
         s2_csum_ff    <= csum_in;
         s2_stopped_ff <= s1_stopped_ff;
      end
   end

   assign cmag = s2_csum_ff[SUM_W-1] ? ~s2_csum_ff : s2_csum_ff;

   always_ff @(posedge clock) begin
      if (take3) begin
         s3_vprod_ff   <= PROD_W'(s2_vsum_ff) * PROD_W'(RECIP);
         s3_cprod_ff   <= PROD_W'(cmag) * PROD_W'(RECIP);
         s3_neg_ff     <= s2_csum_ff[SUM_W-1];
         s3_stopped_ff <= s2_stopped_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: extract averages, compare against limits, av / 3700
   // ------------------------------------------------------------------
   logic [VOLT_W-1:0]  s3_avg_volt;
   logic [CURR_W-1:0]  s3_cquot, s3_avg_curr;
   logic [CPROD_W-1:0] s3_cell_prod;
   logic [VOLT_W-1:0]  s4_avg_volt_ff;
   logic [CURR_W-1:0]  s4_avg_curr_ff;
   logic               s4_stopped_ff, s4_lt_health_ff, s4_lt_one_ff, s4_lt_two_ff;
   logic               s4_lt_three_ff, s4_lt_four_ff, s4_over_ff;
   logic [CELLS_W-1:0] s4_cell_quot_ff;

   always_comb begin
      s3_avg_volt  = s3_vprod_ff[DIV_SHIFT +: VOLT_W];
      s3_cquot     = s3_cprod_ff[DIV_SHIFT +: CURR_W];
      s3_avg_curr  = s3_neg_ff ? ~s3_cquot : s3_cquot;
      s3_cell_prod = CPROD_W'(s3_avg_volt) * CPROD_W'(CELL_RECIP_V);
   end

   always_ff @(posedge clock) begin
      if (take4) begin
         s4_avg_volt_ff  <= s3_avg_volt;
         s4_avg_curr_ff  <= s3_avg_curr;
         s4_stopped_ff   <= s3_stopped_ff;
         s4_lt_health_ff <= s3_avg_volt < health_limit_ff;
         s4_lt_one_ff    <= s3_avg_volt < one_cell_ff;
         s4_lt_two_ff    <= s3_avg_volt < two_cell_ff;
         s4_lt_three_ff  <= s3_avg_volt < three_cell_ff;
         s4_lt_four_ff   <= s3_avg_volt < four_cell_ff;
         s4_over_ff      <= $signed(s3_avg_curr) >= $signed(curr_limit_ff);
         // quotient of a 16-bit voltage by 3700 is at most 17: no saturation
         s4_cell_quot_ff <= s3_cell_prod[CELL_DIV_SHIFT +: CELLS_W];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: candidate cell count and its watermark
   // ------------------------------------------------------------------
   logic [CELLS_W-1:0] s4_cand;
   logic [VOLT_W-1:0]  s5_avg_volt_ff;
   logic [CURR_W-1:0]  s5_avg_curr_ff;
   logic               s5_stopped_ff, s5_lt_health_ff, s5_over_ff;
   logic [CELLS_W-1:0] s5_cand_ff;
   logic [WM_W-1:0]    s5_cand_wm_ff;

   // A nonzero forced count wins; else limits tested in order one to four as written, no sorting
   always_comb begin
      if (forced_cells_ff != '0) begin
         s4_cand = forced_cells_ff;
      end else if (s4_lt_one_ff) begin
         s4_cand = CELLS_W'(1);
      end else if (s4_lt_two_ff) begin
         s4_cand = CELLS_W'(2);
      end else if (s4_lt_three_ff) begin
         s4_cand = CELLS_W'(3);
      end else if (s4_lt_four_ff) begin
         s4_cand = CELLS_W'(4);
      end else begin
         s4_cand = s4_cell_quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take5) begin
         s5_avg_volt_ff  <= s4_avg_volt_ff;
         s5_avg_curr_ff  <= s4_avg_curr_ff;
         s5_stopped_ff   <= s4_stopped_ff;
         s5_lt_health_ff <= s4_lt_health_ff;
         s5_over_ff      <= s4_over_ff;
         s5_cand_ff      <= s4_cand;
         s5_cand_wm_ff   <= WM_W'(s4_cand) * WM_W'(low_level_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: supervisor state update
   // ------------------------------------------------------------------
   mode_type           mode_ff, mode_in;
   logic [CELLS_W-1:0] cells_ff, cells_in;
   logic [WARM_W-1:0]  warm_ff, warm_in;
   logic [LOW_RUN_W-1:0] low_run_ff, low_run_in;
   logic [REPORT_W-1:0]  report_ff, report_in;
   logic [WM_W-1:0]    wm_ff, wm_in;
   logic               over_out, report_out;
   logic [PHASE_W-1:0] phase_out;

   always_comb begin
      mode_in    = mode_ff;
      cells_in   = cells_ff;
      warm_in    = warm_ff;
      low_run_in = low_run_ff;
      report_in  = report_ff;
      wm_in      = WM_W'(cells_ff) * WM_W'(low_level_ff);
      over_out   = 1'b0;
      report_out = 1'b0;
      case (mode_ff)
         MODE_WARM: begin
            if (warm_ff == WARM_W'(WINDOW - 1)) begin
               // first window full: health check and cell count
               warm_in = WARM_W'(WINDOW);
               if (s5_lt_health_ff) begin
                  mode_in = MODE_ABSENT;
               end else begin
                  cells_in = s5_cand_ff;
                  if (s5_fire) begin
                     wm_in = s5_cand_wm_ff;
                  end
                  mode_in = (WM_W'(s5_avg_volt_ff) < s5_cand_wm_ff) ? MODE_SLEEP
                                                                    : MODE_RUN;
               end
            end else begin
               warm_in = warm_ff + 1'b1;
            end
         end
         MODE_RUN: begin
            if (s5_over_ff) begin
               over_out = 1'b1;
            end else begin
               if (s5_stopped_ff && (WM_W'(s5_avg_volt_ff) < wm_ff)) begin
                  if (low_run_ff != '1) begin
                     low_run_in = low_run_ff + 1'b1;
                  end
                  if (low_run_in > LOW_RUN_W'(LOW_RUN_LIMIT)) begin
                     mode_in = MODE_SLEEP;
                  end
               end else begin
                  low_run_in = '0;
               end
               if (mode_in == MODE_RUN) begin
                  report_out = (report_ff == '0);
                  report_in  = (report_ff == REPORT_W'(REPORT_EVERY - 1)) ? '0
                                                                         : report_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WARM;
         cells_ff   <= '0;
         warm_ff    <= '0;
         low_run_ff <= '0;
         report_ff  <= '0;
         wm_ff      <= '0;
      end else begin
         // track the watermark every cycle so register writes reach it
         wm_ff <= wm_in;
         if (s5_fire) begin
            mode_ff    <= mode_in;
            cells_ff   <= cells_in;
            warm_ff    <= warm_in;
            low_run_ff <= low_run_in;
            report_ff  <= report_in;
         end
      end
   end

   // Map the mode after this word to its phase code
   always_comb begin
      case (mode_in)
         MODE_WARM:   phase_out = PHASE_WARM;
         MODE_RUN:    phase_out = PHASE_RUN;
         MODE_ABSENT: phase_out = PHASE_ABSENT;
         MODE_SLEEP:  phase_out = PHASE_SLEEP;
         default:     phase_out = PHASE_WARM;
      endcase
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (take_out) begin
         rsp_data_ff <= {over_out, phase_out, cells_in, s5_avg_curr_ff, s5_avg_volt_ff};
         rsp_user_ff <= report_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
